/* sv/mbps_pkg.sv */
// Shared constants and types for the masked byte pattern search unit.
package mbps_pkg;

  localparam int MAX_PATTERN_DEF  = 40;
  localparam int OFFSET_WIDTH_DEF = 32;

  localparam int SIG_BYTES      = 40;
  localparam int SIG_WORDS      = 5;
  localparam int SIG_WORD_W     = 64;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 3;
  localparam int LEN_CFG_W      = 6;
  localparam int MATCH_OFFSET_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LO     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID_A  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID_B  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID_C  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HI     = 3'd6;

  localparam logic [LEN_CFG_W-1:0] LEN_RESET  = 6'd1;
  localparam logic [SIG_BYTES-1:0] CARE_RESET = '1;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] offset;
  } result_t;

endpackage

/* sv/masked_byte_pattern_search_unit.sv */
// Stages: input register, then byte window and compare, then result register.
// Throughput: one byte per cycle, set by the byte window shift register;
// bytes keep flowing while a result waits, stalling only when a second
// result is produced behind an untaken one.
// Reset: synchronous; clears the pipeline, match state, position count and
// configuration to its defaults (length 1, all bytes compared, zero bytes).
module masked_byte_pattern_search_unit #(
  parameter int MAX_PATTERN  = mbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_WIDTH = mbps_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic [mbps_pkg::MATCH_OFFSET_W-1:0] match_offset
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic                   a_valid;
  logic [7:0]             a_byte;
  logic                   a_last;
  logic                   b_ready;
  logic [LEN_W-1:0]       len;
  logic [7:0]             lane_sig [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] lane_care;
  logic                   out_take;
  logic                   res_valid;
  mbps_pkg::result_t      res;

  mbps_cfg #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .len       (len),
    .lane_sig  (lane_sig),
    .lane_care (lane_care)
  );

  mbps_scan #(
    .MAX_PATTERN  (MAX_PATTERN),
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LEN_W        (LEN_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .a_valid   (a_valid),
    .a_byte    (a_byte),
    .a_last    (a_last),
    .b_ready   (b_ready),
    .len       (len),
    .lane_sig  (lane_sig),
    .lane_care (lane_care),
    .out_take  (out_take),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_ready = !a_valid || b_ready;
  assign out_take = !out_valid || out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= data_byte;
      a_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_valid && out_take) begin
      found        <= res.found;
      match_offset <= res.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= res_valid;
    end
  end

endmodule

/* sv/mbps_cfg.sv */
// Configuration registers and per-lane signature alignment.
module mbps_cfg #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [LEN_W-1:0]                   len,
  output logic [7:0]                         lane_sig [MAX_PATTERN],
  output logic [MAX_PATTERN-1:0]             lane_care
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [mbps_pkg::LEN_CFG_W-1:0]  pattern_length;
  logic [mbps_pkg::SIG_BYTES-1:0]  care_mask;
  logic [mbps_pkg::SIG_WORD_W-1:0] sig_word [mbps_pkg::SIG_WORDS];

  logic [7:0]             src_byte [MAX_PATTERN];
  logic [LEN_W-1:0]       act_len;
  logic [7:0]             lane_sig_next [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] lane_care_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= mbps_pkg::LEN_RESET;
      care_mask      <= mbps_pkg::CARE_RESET;
      for (int w = 0; w < mbps_pkg::SIG_WORDS; w++) begin
        sig_word[w] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[mbps_pkg::LEN_CFG_W-1:0];
        mbps_pkg::REG_CARE_MASK:      care_mask      <= cfg_data[mbps_pkg::SIG_BYTES-1:0];
        mbps_pkg::REG_PATTERN_LO:     sig_word[0]    <= cfg_data;
        mbps_pkg::REG_PATTERN_MID_A:  sig_word[1]    <= cfg_data;
        mbps_pkg::REG_PATTERN_MID_B:  sig_word[2]    <= cfg_data;
        mbps_pkg::REG_PATTERN_MID_C:  sig_word[3]    <= cfg_data;
        mbps_pkg::REG_PATTERN_HI:     sig_word[4]    <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_src
    assign src_byte[k] = sig_word[k / 8][(k % 8) * 8 +: 8];
  end

  // zero acts as one, anything past the window depth is clamped
  always_comb begin
    if (pattern_length == '0) begin
      act_len = LEN_W'(1);
    end else if (pattern_length > mbps_pkg::LEN_CFG_W'(MAX_PATTERN)) begin
      act_len = LEN_W'(MAX_PATTERN);
    end else begin
      act_len = pattern_length[LEN_W-1:0];
    end
  end

  // window slot j (0 = newest) lines up with signature byte len-1-j
  always_comb begin
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      lane_sig_next[j]  = '0;
      lane_care_next[j] = 1'b0;
      if (LEN_W'(j) < act_len) begin
        idx               = IDX_W'(act_len - LEN_W'(j) - LEN_W'(1));
        lane_sig_next[j]  = src_byte[idx];
        lane_care_next[j] = care_mask[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= LEN_W'(1);
      lane_care <= MAX_PATTERN'(1);
      for (int j = 0; j < MAX_PATTERN; j++) begin
        lane_sig[j] <= '0;
      end
    end else begin
      len       <= act_len;
      lane_care <= lane_care_next;
      lane_sig  <= lane_sig_next;
    end
  end

endmodule

/* sv/mbps_scan.sv */
// Byte window, buffer position counter, masked compare and match tracking.
module mbps_scan #(
  parameter int MAX_PATTERN  = mbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_WIDTH = mbps_pkg::OFFSET_WIDTH_DEF,
  parameter int LEN_W        = $clog2(MAX_PATTERN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   a_valid,
  input  logic [7:0]             a_byte,
  input  logic                   a_last,
  output logic                   b_ready,
  input  logic [LEN_W-1:0]       len,
  input  logic [7:0]             lane_sig [MAX_PATTERN],
  input  logic [MAX_PATTERN-1:0] lane_care,
  input  logic                   out_take,
  output logic                   res_valid,
  output mbps_pkg::result_t      res
);

  logic                    b_valid;
  logic                    b_last;
  logic [7:0]              window [MAX_PATTERN];
  logic [OFFSET_WIDTH-1:0] count;
  logic                    matched;

  logic                    b_go;
  logic                    shift;
  logic [MAX_PATTERN-1:0]  mism;
  logic                    hit;
  logic                    new_match;
  logic [OFFSET_WIDTH-1:0] count_base;
  logic [OFFSET_WIDTH-1:0] offset_full;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      mism[j] = lane_care[j] && (window[j] != lane_sig[j]);
    end
  end

  assign hit         = (count >= OFFSET_WIDTH'(len)) && !(|mism);
  assign new_match   = b_valid && !matched && hit;
  assign offset_full = count - OFFSET_WIDTH'(len);

  assign res_valid  = new_match || (b_valid && b_last && !matched);
  assign res.found  = new_match;
  assign res.offset = new_match ? mbps_pkg::MATCH_OFFSET_W'(offset_full) : '0;

  assign b_go    = !res_valid || out_take;
  assign b_ready = !b_valid || b_go;
  assign shift   = a_valid && b_ready;

  // a buffer's last beat leaving this stage restarts the count
  assign count_base = (b_valid && b_last) ? '0 : count;

  always_ff @(posedge clk) begin
    if (shift) begin
      window[0] <= a_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
        window[j] <= window[j-1];
      end
      b_last <= a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      count   <= '0;
      matched <= 1'b0;
    end else begin
      if (shift) begin
        b_valid <= 1'b1;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end

      if (shift) begin
        count <= (count_base == '1) ? count_base : count_base + OFFSET_WIDTH'(1);
      end else if (b_valid && b_go && b_last) begin
        count <= '0;
      end

      if (b_valid && b_go) begin
        matched <= b_last ? 1'b0 : (matched || new_match);
      end
    end
  end

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (count != '0))
    else $error("position count is zero with a beat in the compare stage");

  a_nf_offset: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.offset == '0))
    else $error("not-found result carries a nonzero offset");

  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (b_valid && (b_last || res.found)))
    else $error("result without a match or end of buffer");

  a_match_sticks: assert property (@(posedge clk) disable iff (rst)
    (new_match && b_go && !b_last) |=> matched)
    else $error("match flag not set after a reported match");

  a_buf_clear: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_go && b_last && !shift) |=> (count == '0 && !matched))
    else $error("buffer state not cleared after the last beat");

endmodule
